// File: hw/rtl/line_pair_closest_approach_macros.svh
// Assertion macros for the line pair closest approach block.
// Included by the RTL files that carry concurrent checks.
`ifndef LINE_PAIR_CLOSEST_APPROACH_MACROS_SVH
`define LINE_PAIR_CLOSEST_APPROACH_MACROS_SVH

`ifndef SYNTH
`define LPCA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpca implication check failed");
`define LPCA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpca next-cycle check failed");
`else
`define LPCA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LPCA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/lpca_pkg.sv
// Shared types and widths for the line pair closest approach pipeline.
// No dependencies; line_pair_closest_approach imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lpca_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIR_WIDTH   = 16;
  localparam int IMPACT_W    = 23;
  localparam int ALONG_W     = 24;

  // Fixed-point scale shifts.
  localparam int DEN_SHIFT    = 32;
  localparam int DIRSQ_SHIFT  = 30;
  localparam int IMPACT_SHIFT = 16;
  localparam int ALONG_SHIFT  = 15;

  // Intermediate widths.
  localparam int W_W     = COORD_WIDTH + 1;        // point difference
  localparam int N_W     = 2 * DIR_WIDTH + 1;      // cross product component
  localparam int SQ_W    = 2 * DIR_WIDTH;          // |D|^2
  localparam int B_W     = 2 * DIR_WIDTH + 1;      // D1.D2
  localparam int DEN_W   = 4 * DIR_WIDTH;          // |n|^2
  localparam int NSQ_W   = DEN_W - 1;              // one n component squared
  localparam int DOT_W   = DIR_WIDTH + W_W + 2;    // D.w
  localparam int WNP_W   = W_W + N_W;              // one w*n term
  localparam int WN_W    = WNP_W + 2;              // w.n
  localparam int PRD_W   = DOT_W + B_W;            // b*e and friends
  localparam int NUM_W   = PRD_W + 1;              // numerators of s and t
  localparam int SQD_XW  = DEN_W + DEN_SHIFT;
  localparam int S_W     = SQD_XW / 2;
  localparam int SQA_XW  = SQ_W + DIRSQ_SHIFT;
  localparam int M_W     = SQA_XW / 2;
  localparam int IMPN_W  = WN_W + IMPACT_SHIFT;
  localparam int APROD_W = NUM_W + M_W;
  localparam int ADEN_W  = DEN_W + ALONG_SHIFT;
  localparam int MUL_LAT = 2;

  localparam logic [IMPACT_W-1:0] IMPACT_MAX = {1'b0, {(IMPACT_W-1){1'b1}}} | {1'b1, {(IMPACT_W-1){1'b0}}};
  localparam logic [ALONG_W-1:0]  ALONG_MAX  = {1'b0, {(ALONG_W-1){1'b1}}};
  localparam logic [ALONG_W-1:0]  ALONG_MIN  = {1'b1, {(ALONG_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] line1_point_x;
    logic signed [COORD_WIDTH-1:0] line1_point_y;
    logic signed [COORD_WIDTH-1:0] line1_point_z;
    logic signed [DIR_WIDTH-1:0]   line1_dir_x;
    logic signed [DIR_WIDTH-1:0]   line1_dir_y;
    logic signed [DIR_WIDTH-1:0]   line1_dir_z;
    logic signed [COORD_WIDTH-1:0] line2_point_x;
    logic signed [COORD_WIDTH-1:0] line2_point_y;
    logic signed [COORD_WIDTH-1:0] line2_point_z;
    logic signed [DIR_WIDTH-1:0]   line2_dir_x;
    logic signed [DIR_WIDTH-1:0]   line2_dir_y;
    logic signed [DIR_WIDTH-1:0]   line2_dir_z;
  } pair_t;

  typedef struct packed {
    logic [IMPACT_W-1:0]        impact_distance;
    logic signed [ALONG_W-1:0]  along_line1;
    logic signed [ALONG_W-1:0]  along_line2;
    logic                       lines_parallel;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/lpca_mul.sv
// Two-stage signed multiplier: partial products of operand chunks, then a sum.
// Generic helper for the line pair closest approach pipeline.
`timescale 1ns / 1ps
`default_nettype none

module lpca_mul #(
  parameter int AW    = 35,
  parameter int BW    = 33,
  parameter int PARTS = 2
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CH  = (AW + PARTS - 1) / PARTS;
  localparam int PW  = CH * PARTS;
  localparam int PPW = CH + 1 + BW;
  localparam int SW  = PW + BW;

  logic signed [PW-1:0]  a_ext;
  logic signed [CH:0]    chunk [PARTS];
  logic signed [PPW-1:0] pp_next [PARTS];
  logic signed [PPW-1:0] pp [PARTS];
  logic signed [SW-1:0]  acc;

  assign a_ext = PW'(a);

  // Lower chunks are unsigned; only the top chunk carries the sign.
  always_comb begin
    for (int k = 0; k < PARTS; k++) begin
      if (k == PARTS - 1) begin
        chunk[k] = {a_ext[PW-1], a_ext[k*CH +: CH]};
      end else begin
        chunk[k] = {1'b0, a_ext[k*CH +: CH]};
      end
      pp_next[k] = chunk[k] * b;
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < PARTS; k++) begin
      acc = acc + (SW'(pp[k]) <<< (k * CH));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < PARTS; k++) begin
        pp[k] <= pp_next[k];
      end
      p <= acc[AW+BW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lpca_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Generic helper for the line pair closest approach pipeline.
`timescale 1ns / 1ps
`default_nettype none

module lpca_sqrt #(
  parameter int XW = 62
) (
  input  logic              clk,
  input  logic              en,
  input  logic [XW-1:0]     x,
  output logic [XW/2-1:0]   root
);

  localparam int RW = XW / 2;

  logic [XW-1:0] rem_q [RW];
  logic [RW-1:0] r_q   [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int B = RW - 1 - j;
    logic [XW-1:0] rem_in;
    logic [RW-1:0] r_in;
    logic [XW:0]   trial;

    if (j == 0) begin : g_first
      assign rem_in = x;
      assign r_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign r_in   = r_q[j-1];
    end

    // (r + 2^B)^2 - r^2; r has no bits at or below B, so OR acts as add.
    assign trial = ((XW+1)'(r_in) << (B + 1)) | ((XW+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[j] <= rem_in - trial[XW-1:0];
          r_q[j]   <= r_in | (RW'(1) << B);
        end else begin
          rem_q[j] <= rem_in;
          r_q[j]   <= r_in;
        end
      end
    end
  end

  assign root = r_q[RW-1];

endmodule

`default_nettype wire

// File: hw/rtl/lpca_div.sv
// Pipelined restoring divider with an overflow pre-check, one quotient bit per stage.
// Generic helper for the line pair closest approach pipeline.
`timescale 1ns / 1ps
`default_nettype none

module lpca_div #(
  parameter int NW = 68,
  parameter int DW = 48,
  parameter int QW = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [XW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] q_q   [QW+1];
  logic          ovf_q [QW+1];

  // When the quotient would not fit, the remaining stages produce don't-care bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= XW'(num);
      den_q[0] <= den;
      q_q[0]   <= '0;
      ovf_q[0] <= XW'(num) >= (XW'(den) << QW);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int I = QW - j;
    logic [XW-1:0] t;
    logic          ge;

    assign t  = XW'(den_q[j-1]) << I;
    assign ge = rem_q[j-1] >= t;

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[j]   <= ge ? (q_q[j-1] | (QW'(1) << I)) : q_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end

    if (j < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j] <= ge ? rem_q[j-1] - t : rem_q[j-1];
          den_q[j] <= den_q[j-1];
        end
      end
    end
  end

  assign quo = q_q[QW];
  assign ovf = ovf_q[QW];

endmodule

`default_nettype wire

// File: hw/rtl/lpca_delay.sv
// Enabled shift line that keeps side values aligned with the long arithmetic paths.
// Generic helper for the line pair closest approach pipeline.
`timescale 1ns / 1ps
`default_nettype none

module lpca_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

`default_nettype wire

// File: hw/rtl/line_pair_closest_approach.sv
// Closest approach of two 3D lines. One request (two lines, each a point and a
// direction) may enter every clock cycle; each gives one result.
// The latency is set by the impact path: a 48-step square root of |n|^2 followed
// by a 24-stage divider. The whole pipeline halts while a result is stalled, and
// requests are taken in every cycle in which it does not halt.
// Depends on lpca_pkg, lpca_mul, lpca_sqrt, lpca_div and lpca_delay.
`timescale 1ns / 1ps
`default_nettype none
`include "line_pair_closest_approach_macros.svh"

module line_pair_closest_approach
  import lpca_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    pair_valid,
  output logic    pair_stall,
  input  pair_t   pair,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int T_S3  = 3;
  localparam int T_NUM = T_S3 + MUL_LAT + 2;
  localparam int T_M   = T_S3 + M_W;
  localparam int T_AP  = T_M + MUL_LAT;
  localparam int T_AQ  = T_AP + ALONG_W + 1;
  localparam int T_S   = T_S3 + S_W;
  localparam int T_IQ  = T_S + IMPACT_W + 1;
  localparam int LAT   = T_IQ + 1;

  logic           en;
  logic [LAT:1]   vld;

  assign en           = !(vld[LAT] && result_stall);
  assign pair_stall   = !en;
  assign result_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], pair_valid};
    end
  end

  // Stage 1: differences, cross product and direction dot products.
  logic signed [DIR_WIDTH-1:0] d1_in [3];
  logic signed [DIR_WIDTH-1:0] d2_in [3];
  logic signed [W_W-1:0]       w_in  [3];
  logic signed [N_W-1:0]       n_in  [3];
  logic [SQ_W-1:0]             a_in, c_in;
  logic signed [B_W-1:0]       b_in;

  assign d1_in[0] = pair.line1_dir_x;
  assign d1_in[1] = pair.line1_dir_y;
  assign d1_in[2] = pair.line1_dir_z;
  assign d2_in[0] = pair.line2_dir_x;
  assign d2_in[1] = pair.line2_dir_y;
  assign d2_in[2] = pair.line2_dir_z;
  assign w_in[0]  = W_W'(pair.line1_point_x) - W_W'(pair.line2_point_x);
  assign w_in[1]  = W_W'(pair.line1_point_y) - W_W'(pair.line2_point_y);
  assign w_in[2]  = W_W'(pair.line1_point_z) - W_W'(pair.line2_point_z);
  assign n_in[0]  = d1_in[1] * d2_in[2] - d1_in[2] * d2_in[1];
  assign n_in[1]  = d1_in[2] * d2_in[0] - d1_in[0] * d2_in[2];
  assign n_in[2]  = d1_in[0] * d2_in[1] - d1_in[1] * d2_in[0];
  assign a_in     = d1_in[0] * d1_in[0] + d1_in[1] * d1_in[1] + d1_in[2] * d1_in[2];
  assign b_in     = d1_in[0] * d2_in[0] + d1_in[1] * d2_in[1] + d1_in[2] * d2_in[2];
  assign c_in     = d2_in[0] * d2_in[0] + d2_in[1] * d2_in[1] + d2_in[2] * d2_in[2];

  logic signed [DIR_WIDTH-1:0] d1_1 [3];
  logic signed [DIR_WIDTH-1:0] d2_1 [3];
  logic signed [W_W-1:0]       w_1  [3];
  logic signed [N_W-1:0]       n_1  [3];
  logic [SQ_W-1:0]             a_1, c_1;
  logic signed [B_W-1:0]       b_1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_1[i] <= d1_in[i];
        d2_1[i] <= d2_in[i];
        w_1[i]  <= w_in[i];
        n_1[i]  <= n_in[i];
      end
      a_1 <= a_in;
      b_1 <= b_in;
      c_1 <= c_in;
    end
  end

  // Stage 2: squares of n, D.w products and w*n terms.
  logic [NSQ_W-1:0]        nsq_n [3];
  logic signed [WNP_W-1:0] wnp_n [3];
  logic signed [DOT_W-1:0] dd_n, ee_n;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsq_n[i] = n_1[i] * n_1[i];
      wnp_n[i] = w_1[i] * n_1[i];
    end
    dd_n = d1_1[0] * w_1[0] + d1_1[1] * w_1[1] + d1_1[2] * w_1[2];
    ee_n = d2_1[0] * w_1[0] + d2_1[1] * w_1[1] + d2_1[2] * w_1[2];
  end

  logic [NSQ_W-1:0]        nsq_2 [3];
  logic signed [WNP_W-1:0] wnp_2 [3];
  logic signed [DOT_W-1:0] dd_2, ee_2;
  logic [SQ_W-1:0]         a_2, c_2;
  logic signed [B_W-1:0]   b_2;
  logic                    par_2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nsq_2[i] <= nsq_n[i];
        wnp_2[i] <= wnp_n[i];
      end
      dd_2  <= dd_n;
      ee_2  <= ee_n;
      a_2   <= a_1;
      b_2   <= b_1;
      c_2   <= c_1;
      par_2 <= (n_1[0] == '0) && (n_1[1] == '0) && (n_1[2] == '0);
    end
  end

  // Stage 3: |n|^2 and w.n.
  logic [DEN_W-1:0]        den_3;
  logic signed [WN_W-1:0]  wn_3;
  logic signed [DOT_W-1:0] dd_3, ee_3;
  logic [SQ_W-1:0]         a_3, c_3;
  logic signed [B_W-1:0]   b_3;
  logic                    par_3;

  always_ff @(posedge clk) begin
    if (en) begin
      den_3 <= DEN_W'(nsq_2[0]) + DEN_W'(nsq_2[1]) + DEN_W'(nsq_2[2]);
      wn_3  <= WN_W'(wnp_2[0]) + WN_W'(wnp_2[1]) + WN_W'(wnp_2[2]);
      dd_3  <= dd_2;
      ee_3  <= ee_2;
      a_3   <= a_2;
      b_3   <= b_2;
      c_3   <= c_2;
      par_3 <= par_2;
    end
  end

  logic signed [B_W-1:0] a_3s, c_3s;
  assign a_3s = $signed({1'b0, a_3});
  assign c_3s = $signed({1'b0, c_3});

  // Numerator products for the two line parameters.
  logic signed [PRD_W-1:0] be_5, cd_5, ae_5, bd_5;

  lpca_mul #(.AW(DOT_W), .BW(B_W), .PARTS(2)) u_mul_be (
    .clk(clk), .en(en), .a(ee_3), .b(b_3),  .p(be_5));
  lpca_mul #(.AW(DOT_W), .BW(B_W), .PARTS(2)) u_mul_cd (
    .clk(clk), .en(en), .a(dd_3), .b(c_3s), .p(cd_5));
  lpca_mul #(.AW(DOT_W), .BW(B_W), .PARTS(2)) u_mul_ae (
    .clk(clk), .en(en), .a(ee_3), .b(a_3s), .p(ae_5));
  lpca_mul #(.AW(DOT_W), .BW(B_W), .PARTS(2)) u_mul_bd (
    .clk(clk), .en(en), .a(dd_3), .b(b_3),  .p(bd_5));

  logic signed [NUM_W-1:0] num1_6, num2_6;
  logic [NUM_W-1:0]        mag1_7, mag2_7;
  logic                    neg1_7, neg2_7;

  always_ff @(posedge clk) begin
    if (en) begin
      num1_6 <= NUM_W'(be_5) - NUM_W'(cd_5);
      num2_6 <= NUM_W'(ae_5) - NUM_W'(bd_5);
      neg1_7 <= num1_6[NUM_W-1];
      neg2_7 <= num2_6[NUM_W-1];
      mag1_7 <= num1_6[NUM_W-1] ? NUM_W'(-num1_6) : NUM_W'(num1_6);
      mag2_7 <= num2_6[NUM_W-1] ? NUM_W'(-num2_6) : NUM_W'(num2_6);
    end
  end

  // Square roots: sqrt(|n|^2 * 2^32) for the gap, sqrt(|D|^2 * 2^30) for scaling.
  logic [S_W-1:0] s_root;
  logic [M_W-1:0] m1_root, m2_root;

  lpca_sqrt #(.XW(SQD_XW)) u_sqrt_den (
    .clk(clk), .en(en), .x({den_3, {DEN_SHIFT{1'b0}}}), .root(s_root));
  lpca_sqrt #(.XW(SQA_XW)) u_sqrt_a (
    .clk(clk), .en(en), .x({a_3, {DIRSQ_SHIFT{1'b0}}}), .root(m1_root));
  lpca_sqrt #(.XW(SQA_XW)) u_sqrt_c (
    .clk(clk), .en(en), .x({c_3, {DIRSQ_SHIFT{1'b0}}}), .root(m2_root));

  // Impact path: |w.n| lines up with the root of |n|^2.
  logic [WN_W-1:0] wnm_4, wnm_s;

  always_ff @(posedge clk) begin
    if (en) begin
      wnm_4 <= wn_3[WN_W-1] ? WN_W'(-wn_3) : WN_W'(wn_3);
    end
  end

  lpca_delay #(.W(WN_W), .DEPTH(T_S - 4)) u_dly_wn (
    .clk(clk), .en(en), .d(wnm_4), .q(wnm_s));

  logic [IMPACT_W-1:0] imp_q;
  logic                imp_ovf;

  lpca_div #(.NW(IMPN_W), .DW(S_W), .QW(IMPACT_W)) u_div_imp (
    .clk(clk), .en(en), .num({wnm_s, {IMPACT_SHIFT{1'b0}}}), .den(s_root),
    .quo(imp_q), .ovf(imp_ovf));

  // Along paths: |num| * sqrt scale, then divide by |n|^2 * 2^15.
  logic [NUM_W-1:0]  mag1_m, mag2_m;
  logic [DEN_W-1:0]  den_ap;
  logic [1:0]        neg_iq;
  logic              par_iq;

  lpca_delay #(.W(NUM_W), .DEPTH(T_M - T_NUM)) u_dly_mag1 (
    .clk(clk), .en(en), .d(mag1_7), .q(mag1_m));
  lpca_delay #(.W(NUM_W), .DEPTH(T_M - T_NUM)) u_dly_mag2 (
    .clk(clk), .en(en), .d(mag2_7), .q(mag2_m));
  lpca_delay #(.W(DEN_W), .DEPTH(T_AP - T_S3)) u_dly_den (
    .clk(clk), .en(en), .d(den_3), .q(den_ap));
  lpca_delay #(.W(2), .DEPTH(T_IQ - T_NUM)) u_dly_neg (
    .clk(clk), .en(en), .d({neg2_7, neg1_7}), .q(neg_iq));
  lpca_delay #(.W(1), .DEPTH(T_IQ - T_S3)) u_dly_par (
    .clk(clk), .en(en), .d(par_3), .q(par_iq));

  logic signed [NUM_W+M_W+1:0] ap1, ap2;

  lpca_mul #(.AW(NUM_W + 1), .BW(M_W + 1), .PARTS(3)) u_mul_a1 (
    .clk(clk), .en(en), .a($signed({1'b0, mag1_m})), .b($signed({1'b0, m1_root})),
    .p(ap1));
  lpca_mul #(.AW(NUM_W + 1), .BW(M_W + 1), .PARTS(3)) u_mul_a2 (
    .clk(clk), .en(en), .a($signed({1'b0, mag2_m})), .b($signed({1'b0, m2_root})),
    .p(ap2));

  logic [ALONG_W-1:0] aq1, aq2;
  logic               aovf1, aovf2;

  lpca_div #(.NW(APROD_W), .DW(ADEN_W), .QW(ALONG_W)) u_div_a1 (
    .clk(clk), .en(en), .num(ap1[APROD_W-1:0]), .den({den_ap, {ALONG_SHIFT{1'b0}}}),
    .quo(aq1), .ovf(aovf1));
  lpca_div #(.NW(APROD_W), .DW(ADEN_W), .QW(ALONG_W)) u_div_a2 (
    .clk(clk), .en(en), .num(ap2[APROD_W-1:0]), .den({den_ap, {ALONG_SHIFT{1'b0}}}),
    .quo(aq2), .ovf(aovf2));

  logic [2*ALONG_W+1:0] along_iq;

  lpca_delay #(.W(2 * ALONG_W + 2), .DEPTH(T_IQ - T_AQ)) u_dly_along (
    .clk(clk), .en(en), .d({aovf2, aq2, aovf1, aq1}), .q(along_iq));

  function automatic logic [ALONG_W-1:0] along_clamp(
    input logic               neg,
    input logic               ovf,
    input logic [ALONG_W-1:0] q
  );
    logic [ALONG_W-1:0] res;
    if (!neg) begin
      res = (ovf || q > ALONG_MAX) ? ALONG_MAX : q;
    end else begin
      res = (ovf || q > ALONG_MIN) ? ALONG_MIN : ALONG_W'(-q);
    end
    return res;
  endfunction

  // Output register: saturation, and zeros when the directions are parallel.
  always_ff @(posedge clk) begin
    if (en) begin
      if (par_iq) begin
        result.impact_distance <= '0;
        result.along_line1     <= '0;
        result.along_line2     <= '0;
        result.lines_parallel  <= 1'b1;
      end else begin
        result.impact_distance <= imp_ovf ? IMPACT_MAX : imp_q;
        result.along_line1     <= $signed(along_clamp(neg_iq[0], along_iq[ALONG_W],
                                                      along_iq[ALONG_W-1:0]));
        result.along_line2     <= $signed(along_clamp(neg_iq[1], along_iq[2*ALONG_W+1],
                                                      along_iq[2*ALONG_W:ALONG_W+1]));
        result.lines_parallel  <= 1'b0;
      end
    end
  end

  // An accepted request always occupies the first stage in the next cycle.
  `LPCA_ASSERT_NXT(a_accept_enters, clk, rst, pair_valid && !pair_stall, vld[1])
  // A halted pipeline keeps every valid bit in place.
  `LPCA_ASSERT_NXT(a_halt_holds, clk, rst, !en, $stable(vld))
  // Parallel lines carry zero in every numeric field.
  `LPCA_ASSERT_IMP(a_par_zero, clk, rst, result_valid && result.lines_parallel, result.impact_distance == '0 && result.along_line1 == '0 && result.along_line2 == '0)

endmodule

`default_nettype wire
